>>> hw/rtl/fm_operator_pair_unit_assert.svh
// Assertion macros for the FM operator pair RTL.
`ifndef FM_OPERATOR_PAIR_UNIT_ASSERT_SVH
`define FM_OPERATOR_PAIR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMOP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FMOP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fmop_pkg.sv
package fmop_pkg;

  // Fixed geometry of the oscillator
  localparam int TABLE_SIZE      = 1024;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int SAMPLE_BITS     = 16;

  localparam int IDX_W    = $clog2(TABLE_SIZE);
  localparam int PHASE_W  = IDX_W + PHASE_FRAC_BITS;
  localparam int DEPTH_W  = 31;
  localparam int AMP_W    = 16;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;

  // Quarter-wave table: entry j holds |sin| for table index j of the first quadrant
  localparam int QTAB_SIZE = TABLE_SIZE / 4;
  localparam int QIDX_W    = $clog2(QTAB_SIZE);
  localparam int QMAG_W    = SAMPLE_BITS - 1;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_PEAK   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // Input queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_STEP = 2'd0,
    REG_MOD_STEP     = 2'd1,
    REG_MOD_DEPTH    = 2'd2,
    REG_AMPLITUDE    = 2'd3
  } cfg_reg_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_OFS,
    S_AMP,
    S_DONE
  } back_state_e;

  // Classified command handed from front to back
  typedef struct packed {
    logic restart;
    logic mute;
  } cmd_t;

  // Configuration register set
  typedef struct packed {
    logic [PHASE_W-1:0] carrier_step;
    logic [PHASE_W-1:0] mod_step;
    logic [DEPTH_W-1:0] mod_depth;
    logic [AMP_W-1:0]   amplitude;
  } cfg_t;

  typedef logic [QMAG_W-1:0] qtab_t [QTAB_SIZE];

  // sin(num/TABLE_SIZE * pi/2) in Q30, degree-11 Taylor series (elaboration only)
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] num);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (((num << 30) / TABLE_SIZE) * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  // Rounded and clamped sine magnitude
  function automatic logic [QMAG_W-1:0] sine_mag(input logic [63:0] num);
    logic [63:0] v;
    v = (quarter_sine_q30(num) * SINE_PEAK + (Q30_ONE >> 1)) >> 30;
    if (v > SINE_PEAK) begin
      v = SINE_PEAK;
    end
    return v[QMAG_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int j = 0; j < QTAB_SIZE; j++) begin
      tab[j] = sine_mag(64'(4 * j));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();
  // Peak of the quarter wave, reached from the odd quadrants at offset zero
  localparam logic [QMAG_W-1:0] QTOP = sine_mag(64'(TABLE_SIZE));

endpackage

>>> hw/rtl/fmop_front.sv
module fmop_front
  import fmop_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic restart_i,
  input  logic enable_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic accept;

  // Take a new item whenever the holding register empties this cycle
  assign in_ready_o = !valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Classify: restart request and mute
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.restart <= restart_i;
      cmd_q.mute    <= !enable_i;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> hw/rtl/fmop_queue.sv
module fmop_queue
  import fmop_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hw/rtl/fmop_back.sv
`include "fm_operator_pair_unit_assert.svh"

module fmop_back
  import fmop_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  cmd_t                          cmd_i,
  input  cfg_t                          cfg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int MPROD_W = DEPTH_W + 1 + SAMPLE_BITS;
  localparam int APROD_W = SAMPLE_BITS + AMP_W + 1;
  localparam int Y_W     = APROD_W + 1 - 15;

  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  back_state_e state_q, state_d;
  logic        start, out_load, out_free;
  logic        mute_q;
  logic        out_valid_q, out_valid_d;

  logic [PHASE_W-1:0] car_phase_q, car_phase_d;
  logic [PHASE_W-1:0] mod_phase_q, mod_phase_d;
  logic [PHASE_W-1:0] car_sum;

  logic [IDX_W-1:0]  rom_idx;
  logic [QIDX_W-1:0] qr;
  logic [QMAG_W-1:0] qmag;
  logic signed [SAMPLE_BITS-1:0] sine_d, sine_q;

  logic signed [MPROD_W-1:0] mprod_q;
  logic signed [APROD_W-1:0] aprod_q;
  logic signed [APROD_W:0]   rounded;
  logic signed [Y_W-1:0]     y;
  logic signed [SAMPLE_BITS-1:0] sat, sample_q;

  // Sequencer: lookup, depth multiply, carrier lookup, gain multiply, deliver; a muted item skips to deliver
  always_comb begin
    state_d  = state_q;
    start    = 1'b0;
    out_load = 1'b0;
    out_free = !out_valid_q || out_ready_i;
    case (state_q)
      S_IDLE: begin
        start = cmd_valid_i;
      end
      S_MOD: begin
        state_d = S_OFS;
      end
      S_OFS: begin
        state_d = S_AMP;
      end
      S_AMP: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          start    = cmd_valid_i;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (start) begin
      state_d = cmd_i.mute ? S_DONE : S_MOD;
    end
  end

  assign cmd_ready_o = start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      car_phase_q <= '0;
      mod_phase_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      car_phase_q <= car_phase_d;
      mod_phase_q <= mod_phase_d;
    end
  end

  // Output register: holds a finished sample until transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Carrier phase plus modulation offset, modulo the phase range
  assign car_sum = car_phase_q + mprod_q[PHASE_W+14:15];

  // Phase update: restart clears, each phase advances after its last use
  always_comb begin
    mod_phase_d = mod_phase_q;
    car_phase_d = car_phase_q;
    if (state_q == S_MOD) begin
      mod_phase_d = mod_phase_q + cfg_i.mod_step;
    end
    if (state_q == S_OFS) begin
      car_phase_d = car_phase_q + cfg_i.carrier_step;
    end
    if (start && cmd_i.restart) begin
      mod_phase_d = '0;
      car_phase_d = '0;
    end
  end

  // Shared sine lookup through the quarter-wave table
  always_comb begin
    if (state_q == S_OFS) begin
      rom_idx = car_sum[PHASE_W-1:PHASE_FRAC_BITS];
    end else if (cmd_i.restart) begin
      rom_idx = '0;
    end else begin
      rom_idx = mod_phase_q[PHASE_W-1:PHASE_FRAC_BITS];
    end
    qr = rom_idx[QIDX_W-1:0];
    if (rom_idx[QIDX_W]) begin
      // descending quadrant: mirror the offset
      qmag = (qr == '0) ? QTOP : QTAB[QIDX_W'(0) - qr];
    end else begin
      qmag = QTAB[qr];
    end
    sine_d = rom_idx[QIDX_W+1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  // Round half up by 2^15, then saturate
  always_comb begin
    rounded = {aprod_q[APROD_W-1], aprod_q} + (APROD_W+1)'(16384);
    y       = rounded[APROD_W:15];
    if (y > Y_MAX) begin
      sat = SAMPLE_BITS'(Y_MAX);
    end else if (y < Y_MIN) begin
      sat = SAMPLE_BITS'(Y_MIN);
    end else begin
      sat = y[SAMPLE_BITS-1:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      mute_q <= cmd_i.mute;
    end
    if (start || state_q == S_OFS) begin
      sine_q <= sine_d;
    end
    if (state_q == S_MOD) begin
      mprod_q <= $signed({1'b0, cfg_i.mod_depth}) * sine_q;
    end
    if (state_q == S_AMP) begin
      aprod_q <= sine_q * $signed({1'b0, cfg_i.amplitude});
    end
    if (out_load) begin
      sample_q <= mute_q ? '0 : sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  `FMOP_ASSERT_IMP(a_work_not_muted, clk_i, rst_ni,
    (state_q == S_MOD || state_q == S_OFS || state_q == S_AMP), !mute_q,
    "muted item entered the multiply path")
  `FMOP_ASSERT_NXT(a_start_enabled, clk_i, rst_ni, (start && !cmd_i.mute),
    (state_q == S_MOD), "enabled item did not start its lookup")
  `FMOP_ASSERT_NXT(a_mute_zero, clk_i, rst_ni, (out_load && mute_q),
    (out_valid_q && sample_q == '0), "muted item gave a nonzero sample")
  `FMOP_ASSERT_NXT(a_no_overwrite, clk_i, rst_ni, (out_valid_q && !out_ready_i),
    (out_valid_q && $stable(sample_q)), "pending sample overwritten")

endmodule

>>> hw/rtl/fm_operator_pair_unit.sv
// Channel   Signals                                   Direction
// input     in_valid_i / in_ready_o, restart_i, enable_i   in
// output    out_valid_o / out_ready_i, sample_o            out
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i               in, write only
//
// An enabled item steps through the back-end sequencer: depth multiply,
// carrier add and lookup, gain multiply, round and saturate into the output;
// the modulator lookup overlaps the cycle that takes the item. The single shared
// sine table port and the two multiplies set this sequence. A muted item skips
// straight to the last step, which delivers a zero sample.
// Reset clears phases, configuration, queue and output valid; no clearing pass.
// The front register and a 2-entry queue buffer items while the back stalls; the
// back waits in its last step until the output register is free.
module fm_operator_pair_unit
  import fmop_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  input  logic                          enable_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i
);

  cfg_t cfg_q;
  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CARRIER_STEP: cfg_q.carrier_step <= cfg_wdata_i[PHASE_W-1:0];
        REG_MOD_STEP:     cfg_q.mod_step     <= cfg_wdata_i[PHASE_W-1:0];
        REG_MOD_DEPTH:    cfg_q.mod_depth    <= cfg_wdata_i[DEPTH_W-1:0];
        REG_AMPLITUDE:    cfg_q.amplitude    <= cfg_wdata_i[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fmop_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .enable_i    (enable_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  fmop_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  fmop_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fmop_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          restart_i = 1'b0;
  logic                          enable_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_o;
  logic                          cfg_we_i = 1'b0;
  cfg_reg_e                      cfg_idx_i = REG_CARRIER_STEP;
  logic [CFG_W-1:0]              cfg_wdata_i = '0;

  // Oscillator mirror: registers, phases and sine table
  logic [PHASE_W-1:0] car_inc = '0;
  logic [PHASE_W-1:0] mod_inc = '0;
  logic [DEPTH_W-1:0] depth = '0;
  logic [AMP_W-1:0]   gain = '0;
  logic [PHASE_W-1:0] car_phase = '0;
  logic [PHASE_W-1:0] mod_phase = '0;
  int                 sine_table [TABLE_SIZE];

  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  logic signed [SAMPLE_BITS-1:0] want;
  int unsigned                   errors = 0;
  logic                          idling = 1'b1;
  int unsigned                   hold_cycles = 0;

  fm_operator_pair_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .enable_i   (enable_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sample_o   (sample_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Sine table: quarter-wave fold, Taylor series in Q30, round half up
  initial begin : build_sine
    logic [63:0] q, quad, rem, arg, x, x2, t, v;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      q    = 64'(4 * i);
      quad = q / TABLE_SIZE;
      rem  = q % TABLE_SIZE;
      arg  = quad[0] ? 64'(TABLE_SIZE) - rem : rem;
      x    = (((arg << 30) / TABLE_SIZE) * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      t    = Q30_ONE;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      v    = ((((x * t) >> 30) * SINE_PEAK) + (Q30_ONE >> 1)) >> 30;
      if (v > SINE_PEAK) begin
        v = SINE_PEAK;
      end
      sine_table[i] = quad[1] ? -int'(v) : int'(v);
    end
  end

  // One oscillator tick: returns the sample and, unless muted, advances the mirrored phases
  function automatic logic signed [SAMPLE_BITS-1:0] next_sample(input logic rs,
                                                                input logic en);
    longint             offset;
    longint             level;
    logic [PHASE_W-1:0] peek;
    if (rs) begin
      car_phase = '0;
      mod_phase = '0;
    end
    if (!en) begin
      return '0;
    end
    offset = (longint'(depth) * longint'(sine_table[mod_phase[PHASE_W-1 -: IDX_W]]))
             >>> (SAMPLE_BITS - 1);
    // offset wraps modulo the phase range in either direction
    peek  = car_phase + offset[PHASE_W-1:0];
    level = (longint'(sine_table[peek[PHASE_W-1 -: IDX_W]]) * longint'(gain)
             + 64'sd16384) >>> 15;
    if (level > SAMPLE_HI) begin
      level = SAMPLE_HI;
    end
    if (level < SAMPLE_LO) begin
      level = SAMPLE_LO;
    end
    car_phase = car_phase + car_inc;
    mod_phase = mod_phase + mod_inc;
    return SAMPLE_BITS'(level);
  endfunction

  // Register writes, input transfers and output checks, in that order per edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CARRIER_STEP: car_inc = cfg_wdata_i[PHASE_W-1:0];
          REG_MOD_STEP:     mod_inc = cfg_wdata_i[PHASE_W-1:0];
          REG_MOD_DEPTH:    depth   = cfg_wdata_i[DEPTH_W-1:0];
          REG_AMPLITUDE:    gain    = cfg_wdata_i[AMP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        expected_samples.push_back(next_sample(restart_i, enable_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("sample: expected none, actual %0d", sample_o);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (sample_o !== want) begin
            $error("sample: expected %0d, actual %0d", want, sample_o);
            errors++;
          end
        end
      end
    end
  end

  // Output side: random stall bursts, plus a long hold on request
  initial begin : sink
    forever begin
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // One input transfer, with an optional gap in front
  task automatic send_note(input logic rs, input logic en);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    enable_i   <= en;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every sample has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back
  task automatic program_voice(input logic [PHASE_W-1:0] c_step, m_step,
                               input logic [DEPTH_W-1:0] m_depth,
                               input logic [AMP_W-1:0] amp);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_CARRIER_STEP;
    cfg_wdata_i <= CFG_W'(c_step);
    @(posedge clk_i);
    cfg_idx_i   <= REG_MOD_STEP;
    cfg_wdata_i <= CFG_W'(m_step);
    @(posedge clk_i);
    cfg_idx_i   <= REG_MOD_DEPTH;
    cfg_wdata_i <= CFG_W'(m_depth);
    @(posedge clk_i);
    cfg_idx_i   <= REG_AMPLITUDE;
    cfg_wdata_i <= CFG_W'(amp);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [PHASE_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return PHASE_W'($urandom());
      default: return PHASE_W'($urandom_range(0, (1 << 22) - 1));
    endcase
  endfunction

  // Registers at reset: zero gain, so every sample is zero
  task automatic test_reset_state();
    send_note(1'b0, 1'b1);
    send_note(1'b0, 1'b0);
    wait_idle();
  endtask

  // Quarter-period carrier steps land on zero crossings and both peaks
  task automatic test_pure_sine();
    program_voice(PHASE_W'(QTAB_SIZE) << PHASE_FRAC_BITS, '0, '0, AMP_W'(32768));
    send_note(1'b1, 1'b1);
    repeat (4) send_note(1'b0, 1'b1);
    wait_idle();
  endtask

  // Gain above unity saturates at both ends of the sample range
  task automatic test_gain_saturation();
    program_voice(PHASE_W'(QTAB_SIZE) << PHASE_FRAC_BITS, '0, '0, '1);
    send_note(1'b1, 1'b1);
    repeat (4) send_note(1'b0, 1'b1);
    wait_idle();
  endtask

  // Muted ticks hold the phases; restart while muted still clears them
  task automatic test_muting();
    program_voice(PHASE_W'(3) << PHASE_FRAC_BITS, PHASE_W'(5) << PHASE_FRAC_BITS,
                  DEPTH_W'(40) << PHASE_FRAC_BITS, AMP_W'(32768));
    send_note(1'b0, 1'b1);
    send_note(1'b0, 1'b0);
    send_note(1'b0, 1'b1);
    send_note(1'b1, 1'b0);
    send_note(1'b0, 1'b1);
    wait_idle();
  endtask

  // Largest steps and depth: phase wrap and offset wrap in both directions
  task automatic test_extreme_steps();
    program_voice('1, '1, '1, AMP_W'(32768));
    send_note(1'b1, 1'b1);
    repeat (4) send_note(1'b0, 1'b1);
    wait_idle();
  endtask

  // Output held off for a long stretch while input keeps coming
  task automatic test_backpressure();
    program_voice(PHASE_W'($urandom_range(0, (1 << 22) - 1)),
                  PHASE_W'($urandom_range(0, (1 << 22) - 1)),
                  DEPTH_W'($urandom_range(0, (1 << 24) - 1)), AMP_W'(20000));
    hold_cycles = 80;
    for (int n = 0; n < 24; n++) begin
      send_note(n == 0, $urandom_range(0, 5) != 0);
    end
    wait_idle();
  endtask

  // Random voices, one register setting per phase; no idling at the end
  task automatic test_random_voices(input int phases, input int per_phase);
    logic [DEPTH_W-1:0] m_depth;
    logic [AMP_W-1:0]   amp;
    for (int p = 0; p < phases; p++) begin
      if (p >= phases - 2) begin
        idling = 1'b0;
      end
      case ($urandom_range(0, 4))
        0:       m_depth = '0;
        1:       m_depth = '1;
        2:       m_depth = DEPTH_W'($urandom());
        default: m_depth = DEPTH_W'($urandom_range(0, (1 << 24) - 1));
      endcase
      case ($urandom_range(0, 5))
        0:       amp = '0;
        1:       amp = AMP_W'(32768);
        2:       amp = AMP_W'($urandom());
        default: amp = AMP_W'($urandom_range(0, 32768));
      endcase
      program_voice(pick_step(), pick_step(), m_depth, amp);
      for (int n = 0; n < per_phase; n++) begin
        send_note($urandom_range(0, 19) == 0, $urandom_range(0, 6) != 0);
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_state();
    test_pure_sine();
    test_gain_saturation();
    test_muting();
    test_extreme_steps();
    test_backpressure();
    test_random_voices(10, 125);
    if (errors == 0) begin
      $display("fm_operator_pair_unit test passed");
    end else begin
      $display("fm_operator_pair_unit test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("fm_operator_pair_unit test failed");
    $finish;
  end

endmodule
